// File: hw/rtl/paa_pkg.sv
package paa_pkg;

   localparam int PAGE_SLOTS_DEFAULT = 16;
   localparam logic [15:0] DEFAULT_PAGE_BYTES_RESET = 16'd4096;

   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_BEGIN   = 2'd1;
   localparam logic [1:0] ACT_END     = 2'd2;
   localparam logic [1:0] ACT_DISPOSE = 2'd3;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] request_bytes;
   } paa_req_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  page_index;
      logic [15:0] block_offset;
      logic [19:0] arena_total;
   } paa_rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_FIT_RD,
      OP_FIT_DO,
      OP_SCAN_INIT,
      OP_SCAN_RDFL,
      OP_SCAN_RDCAP,
      OP_SCAN_NEXT,
      OP_TAKE_RD,
      OP_TAKE_WR,
      OP_CHAIN,
      OP_FAIL,
      OP_BEGIN_RD,
      OP_BEGIN_WR,
      OP_DISP_START,
      OP_RB_RD,
      OP_RB_LOAD,
      OP_WALK_GIVE,
      OP_WALK_LOAD,
      OP_DISP_FIN,
      OP_RB_FIN,
      OP_RESPOND
   } paa_op_type;

   typedef struct packed {
      paa_op_type op;
   } paa_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       first;
      logic       fit_ok;
      logic       ft_zero;
      logic       hit;
      logic       scan_last;
      logic       phase2;
      logic       walk_go;
      logic       p_is_tail;
      logic       mark_valid;
      logic       rsp_free;
   } paa_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FIT_RD,
      ST_FIT_CHK,
      ST_SCAN_INIT,
      ST_SCAN_RDFL,
      ST_SCAN_RDCAP,
      ST_SCAN_CHK,
      ST_SCAN_NEXT,
      ST_TAKE_RD,
      ST_TAKE_WR,
      ST_CHAIN,
      ST_FAIL,
      ST_BEGIN_RD,
      ST_BEGIN_WR,
      ST_DISP_START,
      ST_RB_RD,
      ST_RB_LOAD,
      ST_WALK_CHK,
      ST_WALK_GIVE,
      ST_WALK_LOAD,
      ST_DISP_FIN,
      ST_RB_FIN,
      ST_RESPOND
   } paa_state_type;

endpackage

// File: hw/rtl/paa_controller.sv
module paa_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  paa_pkg::paa_status_type st,
   output paa_pkg::paa_cmd_type    cmd
);
   import paa_pkg::*;

   paa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (st.action)
               ACT_PUSH:  state_in = st.first ? ST_SCAN_INIT : ST_FIT_RD;
               ACT_BEGIN: state_in = ST_BEGIN_RD;
               ACT_END:   state_in = st.mark_valid ? ST_RB_RD : ST_DISP_START;
               default:   state_in = ST_DISP_START;
            endcase
         end
         ST_FIT_RD: begin
            cmd.op   = OP_FIT_RD;
            state_in = ST_FIT_CHK;
         end
         ST_FIT_CHK: begin
            if (st.fit_ok) begin
               cmd.op   = OP_FIT_DO;
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_SCAN_INIT;
            end
         end
         ST_SCAN_INIT: begin
            cmd.op   = OP_SCAN_INIT;
            state_in = st.ft_zero ? ST_FAIL : ST_SCAN_RDFL;
         end
         ST_SCAN_RDFL: begin
            cmd.op   = OP_SCAN_RDFL;
            state_in = ST_SCAN_RDCAP;
         end
         ST_SCAN_RDCAP: begin
            cmd.op   = OP_SCAN_RDCAP;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (st.hit) begin
               state_in = ST_TAKE_RD;
            end else if (st.scan_last && st.phase2) begin
               state_in = ST_FAIL;
            end else begin
               state_in = ST_SCAN_NEXT;
            end
         end
         ST_SCAN_NEXT: begin
            cmd.op   = OP_SCAN_NEXT;
            state_in = ST_SCAN_RDFL;
         end
         ST_TAKE_RD: begin
            cmd.op   = OP_TAKE_RD;
            state_in = ST_TAKE_WR;
         end
         ST_TAKE_WR: begin
            cmd.op   = OP_TAKE_WR;
            state_in = ST_CHAIN;
         end
         ST_CHAIN: begin
            cmd.op   = OP_CHAIN;
            state_in = ST_RESPOND;
         end
         ST_FAIL: begin
            cmd.op   = OP_FAIL;
            state_in = ST_RESPOND;
         end
         ST_BEGIN_RD: begin
            cmd.op   = OP_BEGIN_RD;
            state_in = ST_BEGIN_WR;
         end
         ST_BEGIN_WR: begin
            cmd.op   = OP_BEGIN_WR;
            state_in = ST_RESPOND;
         end
         ST_DISP_START: begin
            cmd.op   = OP_DISP_START;
            state_in = ST_WALK_CHK;
         end
         ST_RB_RD: begin
            cmd.op   = OP_RB_RD;
            state_in = ST_RB_LOAD;
         end
         ST_RB_LOAD: begin
            cmd.op   = OP_RB_LOAD;
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (st.walk_go) begin
               state_in = ST_WALK_GIVE;
            end else if (st.mark_valid && st.action == ACT_END) begin
               state_in = ST_RB_FIN;
            end else begin
               state_in = ST_DISP_FIN;
            end
         end
         ST_WALK_GIVE: begin
            cmd.op = OP_WALK_GIVE;
            if (st.mark_valid && st.action == ACT_END && st.p_is_tail) begin
               state_in = ST_RB_FIN;
            end else begin
               state_in = ST_WALK_LOAD;
            end
         end
         ST_WALK_LOAD: begin
            cmd.op   = OP_WALK_LOAD;
            state_in = ST_WALK_CHK;
         end
         ST_DISP_FIN: begin
            cmd.op   = OP_DISP_FIN;
            state_in = ST_RESPOND;
         end
         ST_RB_FIN: begin
            cmd.op   = OP_RB_FIN;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (st.rsp_free) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/paa_datapath.sv
module paa_datapath #(
   parameter int PAGE_SLOTS = paa_pkg::PAGE_SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [15:0]             csr_write_data,
   input  paa_pkg::paa_req_type    req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output paa_pkg::paa_rsp_type    rsp_payload,
   input  paa_pkg::paa_cmd_type    cmd,
   output paa_pkg::paa_status_type st
);
   import paa_pkg::*;

   localparam int PW = $clog2(PAGE_SLOTS);
   localparam int CW = $clog2(PAGE_SLOTS + 1);
   localparam logic [PW:0] NONE_REF = {1'b1, {PW{1'b0}}};

   // Page references carry a none flag in their top bit.
   logic [PW-1:0] fl_mem   [PAGE_SLOTS];
   logic [15:0]   cap_mem  [PAGE_SLOTS];
   logic [15:0]   fill_mem [PAGE_SLOTS];
   logic [PW:0]   link_mem [PAGE_SLOTS];

   logic [PAGE_SLOTS-1:0] backed_ff, flw_ff;
   logic [PW:0]   head_ff, tail_ff, mark_ff, walk_ff;
   logic [20:0]   held_ff, mark_bytes_ff;
   logic [15:0]   mark_fill_ff, def_ff, req_bytes_ff;
   logic [1:0]    req_action_ff;
   logic [CW-1:0] ft_ff, guard_ff;
   logic [PW-1:0] idx_ff, pg_ff;
   logic          phase2_ff, rsp_valid_ff;
   logic          res_status_ff;
   logic [3:0]    res_pidx_ff;
   logic [15:0]   res_offs_ff;
   paa_rsp_type   rsp_ff;

   logic [PW-1:0] fl_rd_ff, fl_addr_ff;
   logic          fl_wr_ff;
   logic [15:0]   cap_rd_ff, fill_rd_ff;
   logic [PW:0]   link_rd_ff;

   logic [PW-1:0] fl_raddr, cap_raddr, fill_raddr, link_raddr, fl_q;
   logic [CW-1:0] ft_dec;
   logic [15:0]   cap_new;
   paa_op_type    op;

   assign op      = cmd.op;
   assign ft_dec  = ft_ff - CW'(1);
   assign fl_q    = fl_wr_ff ? fl_rd_ff : fl_addr_ff;
   assign cap_new = (req_bytes_ff > def_ff) ? req_bytes_ff : def_ff;

   always_comb begin
      fl_raddr   = (op == OP_TAKE_RD) ? ft_dec[PW-1:0] : idx_ff;
      cap_raddr  = (op == OP_FIT_RD) ? tail_ff[PW-1:0] : fl_q;
      fill_raddr = tail_ff[PW-1:0];
      link_raddr = (op == OP_RB_RD) ? mark_ff[PW-1:0] : walk_ff[PW-1:0];
   end

   always_ff @(posedge clock) begin
      fl_rd_ff   <= fl_mem[fl_raddr];
      fl_addr_ff <= fl_raddr;
      fl_wr_ff   <= flw_ff[fl_raddr];
      cap_rd_ff  <= cap_mem[cap_raddr];
      fill_rd_ff <= fill_mem[fill_raddr];
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (op == OP_WALK_GIVE && ft_ff < CW'(PAGE_SLOTS)) begin
         fl_mem[ft_ff[PW-1:0]] <= walk_ff[PW-1:0];
      end else if (op == OP_TAKE_WR) begin
         fl_mem[idx_ff] <= fl_q;
      end
      if (op == OP_TAKE_WR && phase2_ff) begin
         cap_mem[pg_ff] <= cap_new;
      end
      case (op)
         OP_FIT_DO:  fill_mem[tail_ff[PW-1:0]] <= fill_rd_ff + req_bytes_ff;
         OP_TAKE_WR: fill_mem[pg_ff] <= req_bytes_ff;
         OP_RB_FIN:  fill_mem[mark_ff[PW-1:0]] <= mark_fill_ff;
         default: ;
      endcase
      case (op)
         OP_TAKE_WR: link_mem[pg_ff] <= NONE_REF;
         OP_CHAIN: begin
            if (!(head_ff[PW] || tail_ff[PW])) begin
               link_mem[tail_ff[PW-1:0]] <= {1'b0, pg_ff};
            end
         end
         OP_RB_FIN:  link_mem[mark_ff[PW-1:0]] <= NONE_REF;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LATCH: begin
            req_action_ff <= req_payload.action;
            req_bytes_ff  <= req_payload.request_bytes;
            res_status_ff <= STATUS_DONE;
            res_pidx_ff   <= 4'd0;
            res_offs_ff   <= 16'd0;
         end
         OP_FIT_DO: begin
            res_pidx_ff <= 4'(tail_ff[PW-1:0]);
            res_offs_ff <= fill_rd_ff;
         end
         OP_SCAN_RDCAP: pg_ff <= fl_q;
         OP_CHAIN: begin
            res_pidx_ff <= 4'(pg_ff);
            res_offs_ff <= 16'd0;
         end
         OP_FAIL: begin
            res_status_ff <= STATUS_REFUSED;
            res_pidx_ff   <= 4'd0;
            res_offs_ff   <= 16'd0;
         end
         OP_DISP_START: walk_ff <= head_ff;
         OP_RB_LOAD, OP_WALK_LOAD: walk_ff <= link_rd_ff;
         OP_RESPOND: begin
            rsp_ff.status       <= res_status_ff;
            rsp_ff.page_index   <= res_pidx_ff;
            rsp_ff.block_offset <= res_offs_ff;
            rsp_ff.arena_total  <= held_ff[19:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backed_ff     <= '0;
         flw_ff        <= '0;
         head_ff       <= NONE_REF;
         tail_ff       <= NONE_REF;
         mark_ff       <= NONE_REF;
         held_ff       <= '0;
         mark_bytes_ff <= '0;
         mark_fill_ff  <= '0;
         ft_ff         <= CW'(PAGE_SLOTS);
         guard_ff      <= '0;
         idx_ff        <= '0;
         phase2_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         def_ff        <= DEFAULT_PAGE_BYTES_RESET;
      end else begin
         if (csr_write_enable) begin
            def_ff <= csr_write_data;
         end
         if (op == OP_RESPOND) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (op)
            OP_FIT_DO: held_ff <= held_ff + {5'd0, req_bytes_ff};
            OP_SCAN_INIT: begin
               idx_ff    <= '0;
               phase2_ff <= 1'b0;
            end
            OP_SCAN_NEXT: begin
               if (CW'(idx_ff) == ft_dec) begin
                  idx_ff    <= '0;
                  phase2_ff <= 1'b1;
               end else begin
                  idx_ff <= idx_ff + PW'(1);
               end
            end
            OP_TAKE_WR: begin
               ft_ff        <= ft_dec;
               flw_ff[idx_ff] <= 1'b1;
               if (phase2_ff) begin
                  backed_ff[pg_ff] <= 1'b1;
               end
            end
            OP_CHAIN: begin
               if (head_ff[PW] || tail_ff[PW]) begin
                  head_ff <= {1'b0, pg_ff};
               end
               tail_ff <= {1'b0, pg_ff};
               held_ff <= held_ff + {5'd0, req_bytes_ff};
            end
            OP_BEGIN_WR: begin
               mark_ff       <= tail_ff;
               mark_bytes_ff <= held_ff;
               mark_fill_ff  <= tail_ff[PW] ? 16'd0 : fill_rd_ff;
            end
            OP_DISP_START, OP_RB_LOAD: guard_ff <= '0;
            OP_WALK_GIVE: begin
               guard_ff <= guard_ff + CW'(1);
               if (ft_ff < CW'(PAGE_SLOTS)) begin
                  ft_ff <= ft_ff + CW'(1);
                  flw_ff[ft_ff[PW-1:0]] <= 1'b1;
               end
            end
            OP_DISP_FIN: begin
               head_ff       <= NONE_REF;
               tail_ff       <= NONE_REF;
               held_ff       <= '0;
               mark_bytes_ff <= '0;
               mark_ff       <= NONE_REF;
               mark_fill_ff  <= '0;
            end
            OP_RB_FIN: begin
               tail_ff <= mark_ff;
               held_ff <= mark_bytes_ff;
               mark_ff <= NONE_REF;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      st.action     = req_action_ff;
      st.first      = head_ff[PW] | tail_ff[PW];
      st.fit_ok     = (fill_rd_ff <= cap_rd_ff) && ((cap_rd_ff - fill_rd_ff) >= req_bytes_ff);
      st.ft_zero    = (ft_ff == '0);
      st.hit        = phase2_ff ? !backed_ff[pg_ff]
                                : (backed_ff[pg_ff] && (cap_rd_ff > req_bytes_ff));
      st.scan_last  = (CW'(idx_ff) == ft_dec);
      st.phase2     = phase2_ff;
      st.walk_go    = !walk_ff[PW] && (guard_ff < CW'(PAGE_SLOTS));
      st.p_is_tail  = !walk_ff[PW] && (walk_ff == tail_ff);
      st.mark_valid = !mark_ff[PW];
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff[PW] == tail_ff[PW])
      else $error("head and tail disagree on an empty arena");
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      ft_ff <= CW'(PAGE_SLOTS))
      else $error("free list count beyond pool size");
   a_take_unbacked: assert property (@(posedge clock) disable iff (reset)
      (op == OP_TAKE_WR && phase2_ff) |-> !backed_ff[pg_ff])
      else $error("second pass took a page that is already backed");
   a_in_use_backed: assert property (@(posedge clock) disable iff (reset)
      ($countones(backed_ff) + int'(ft_ff)) >= PAGE_SLOTS)
      else $error("a page outside the free list is not backed");

endmodule

// File: hw/rtl/paged_arena_allocator.sv
// Paged arena allocator.
// Requests enter on the req_ channel (valid/ready) carrying an action and a
// byte count; each request produces exactly one result on the rsp_ channel
// (valid/ready) with a status, the page and offset of a pushed block, and
// the bytes held by the arena afterwards.
// The block works on one request at a time. A push that fits the current
// page reads, checks and updates the tail page's fill, then responds. A
// push that needs a page scans the free list one entry at a time, in up to
// two passes (backed pages first, then an unbacked one). A rollback or
// dispose walks the page chain one page at a time. Each scan step reads a
// free-list entry and then that page's capacity; each walk step reads one
// link entry.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and works on the next request, holding its result back
// until the register is emptied.
// The default page size register is written through csr_write_enable and
// csr_write_data; the user must do so only while the block is idle, which
// the block does not enforce. Reset (synchronous, active high) empties the
// arena, returns every page to the free list unbacked and sets the default
// page size to 4096; it takes effect at once, with no clearing pass.
module paged_arena_allocator #(
   parameter int PAGE_SLOTS = paa_pkg::PAGE_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [15:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  paa_pkg::paa_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output paa_pkg::paa_rsp_type rsp_payload
);
   import paa_pkg::*;

   // Command and status travel between the sequencer and the datapath.
   paa_cmd_type    cmd;
   paa_status_type st;

   paa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath owns the page pool memories, the free list and the
   // arena registers, as well as the result register.
   paa_datapath #(
      .PAGE_SLOTS (PAGE_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .st               (st)
   );

endmodule

// File: tb/sv/tb_paged_arena_allocator.sv
module tb_paged_arena_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import paa_pkg::*;

   localparam int SLOTS      = 16;
   localparam int NONE       = -1;
   localparam int DRAIN_WAIT = 150;   // a little over the longest page scan
   localparam int CYCLE_CAP  = 2000000;
   localparam int HOLD_LEN   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   paa_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   paa_rsp_type rsp_payload;

   paged_arena_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

   always #4 clock = ~clock;

   // Requests still to be offered, and the results the arena model says are owed.
   paa_req_type pending_requests[$];
   paa_rsp_type expected_results[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count   = 0;

   // Long receiver hold-off, counted in its own process.
   logic start_hold = 1'b0;
   logic hold_used  = 1'b0;
   int   hold_left  = 0;

   // ------------------------------------------------------------------
   // Arena model: our own copy of the page pool and the checkpoint.
   // ------------------------------------------------------------------
   bit          pool_backed[SLOTS];
   logic [15:0] pool_capacity[SLOTS];
   logic [15:0] pool_fill[SLOTS];
   int          pool_link[SLOTS];
   int          spare_list[SLOTS];
   int          spare_count;
   int          chain_head, chain_tail;
   logic [20:0] arena_bytes;
   int          cp_page;
   logic [20:0] cp_bytes;
   logic [15:0] cp_fill;
   logic [15:0] min_page_bytes;

   function automatic bit valid_page(int p);
      return p >= 0 && p < SLOTS;
   endfunction

   function automatic void arena_clear();
      for (int i = 0; i < SLOTS; i++) begin
         pool_backed[i] = 1'b0;
         pool_capacity[i] = '0;
         pool_fill[i] = '0;
         pool_link[i] = 0;
         spare_list[i] = i;
      end
      spare_count = SLOTS;
      chain_head = NONE;
      chain_tail = NONE;
      arena_bytes = '0;
      cp_page = NONE;
      cp_bytes = '0;
      cp_fill = '0;
      min_page_bytes = DEFAULT_PAGE_BYTES_RESET;
   endfunction

   function automatic void claim_slot(int slot, int pg);
      spare_count--;
      spare_list[slot] = spare_list[spare_count];
      pool_link[pg] = NONE;
      pool_fill[pg] = '0;
   endfunction

   // Backed pages that are strictly larger win; otherwise the first unbacked one.
   function automatic int claim_page(logic [15:0] need);
      logic [15:0] cap;
      int pg;
      for (int i = 0; i < spare_count; i++) begin
         pg = spare_list[i];
         if (valid_page(pg) && pool_backed[pg] && pool_capacity[pg] > need) begin
            claim_slot(i, pg);
            return pg;
         end
      end
      cap = (need > min_page_bytes) ? need : min_page_bytes;
      for (int i = 0; i < spare_count; i++) begin
         pg = spare_list[i];
         if (valid_page(pg) && !pool_backed[pg]) begin
            claim_slot(i, pg);
            pool_backed[pg] = 1'b1;
            pool_capacity[pg] = cap;
            return pg;
         end
      end
      return NONE;
   endfunction

   function automatic void release_page(int pg);
      if (spare_count < SLOTS) begin
         spare_list[spare_count] = pg;
         spare_count++;
      end
   endfunction

   function automatic void release_all();
      int p;
      int steps;
      p = chain_head;
      steps = 0;
      while (valid_page(p) && steps < SLOTS) begin
         release_page(p);
         p = pool_link[p];
         steps++;
      end
      chain_head = NONE;
      chain_tail = NONE;
      arena_bytes = '0;
      cp_bytes = '0;
      cp_page = NONE;
      cp_fill = '0;
   endfunction

   function automatic void rewind_to_mark();
      int p;
      int steps;
      if (!valid_page(cp_page)) begin
         release_all();
         return;
      end
      p = pool_link[cp_page];
      steps = 0;
      while (valid_page(p) && steps < SLOTS) begin
         release_page(p);
         if (p == chain_tail) break;
         p = pool_link[p];
         steps++;
      end
      chain_tail = cp_page;
      arena_bytes = cp_bytes;
      pool_fill[chain_tail] = cp_fill;
      pool_link[chain_tail] = NONE;
      cp_page = NONE;
   endfunction

   function automatic paa_rsp_type arena_step(paa_req_type rq);
      paa_rsp_type r;
      bit ok;
      int pg, t;
      logic [15:0] need, cap, fill;
      r = '0;
      need = rq.request_bytes;
      case (rq.action)
         ACT_PUSH: begin
            ok = 1'b1;
            if (!valid_page(chain_head) || !valid_page(chain_tail)) begin
               pg = claim_page(need);
               if (pg == NONE) ok = 1'b0;
               else begin
                  chain_head = pg;
                  chain_tail = pg;
               end
            end
            if (ok) begin
               t = chain_tail;
               cap = pool_capacity[t];
               fill = pool_fill[t];
               if (fill <= cap && 16'(cap - fill) >= need) begin
                  r.page_index = t[3:0];
                  r.block_offset = fill;
                  pool_fill[t] = 16'(fill + need);
                  arena_bytes = 21'(arena_bytes + need);
               end else begin
                  pg = claim_page(need);
                  if (pg == NONE) ok = 1'b0;
                  else begin
                     pool_link[t] = pg;
                     chain_tail = pg;
                     pool_fill[pg] = need;
                     arena_bytes = 21'(arena_bytes + need);
                     r.page_index = pg[3:0];
                     r.block_offset = '0;
                  end
               end
            end
            if (!ok) begin
               r.status = STATUS_REFUSED;
               r.page_index = '0;
               r.block_offset = '0;
            end
         end
         ACT_BEGIN: begin
            cp_page = chain_tail;
            cp_bytes = arena_bytes;
            cp_fill = valid_page(chain_tail) ? pool_fill[chain_tail] : 16'd0;
         end
         ACT_END: rewind_to_mark();
         default: release_all();
      endcase
      r.arena_total = arena_bytes[19:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers the pending requests, idling at random between them.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off so that the block backs up.
   always @(posedge clock) begin
      if (start_hold && !hold_used) begin
         hold_left <= HOLD_LEN;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left != 0 || (start_hold && !hold_used))
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("ERROR at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Monitor: every accepted request is run through the arena model, and
   // every accepted result is checked against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      paa_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(arena_step(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("results outstanding", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.page_index !== want.page_index)
                  report_mismatch("page_index", rsp_payload.page_index, want.page_index);
               if (rsp_payload.block_offset !== want.block_offset)
                  report_mismatch("block_offset", rsp_payload.block_offset,
                                  want.block_offset);
               if (rsp_payload.arena_total !== want.arena_total)
                  report_mismatch("arena_total", rsp_payload.arena_total, want.arena_total);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencing helpers.
   // ------------------------------------------------------------------
   function automatic void add_request(logic [1:0] act, logic [15:0] bytes);
      paa_req_type rq;
      rq.action = act;
      rq.request_bytes = bytes;
      pending_requests.push_back(rq);
   endfunction

   // Waits until every request has gone in and every result has come back,
   // then lets the block settle.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_page_default(logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      min_page_bytes = value;
   endtask

   // Mostly pushes of modest size with checkpoints, rollbacks and disposes
   // mixed in; now and then a full-range byte count to exercise every request bit.
   function automatic void add_random_requests(int n);
      int pick;
      logic [15:0] bytes;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         case ($urandom_range(9))
            0:       bytes = 16'($urandom);
            1, 2:    bytes = 16'($urandom_range(8000));
            3:       bytes = 16'($urandom_range(3));
            default: bytes = 16'($urandom_range(600));
         endcase
         if (pick < 68)      add_request(ACT_PUSH, bytes);
         else if (pick < 80) add_request(ACT_BEGIN, bytes);
         else if (pick < 92) add_request(ACT_END, bytes);
         else                add_request(ACT_DISPOSE, bytes);
      end
   endfunction

   task automatic run_phase(int n, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      add_random_requests(n);
      wait_drained();
   endtask

   initial begin
      arena_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset default of 4096 bytes per page.
      add_request(ACT_BEGIN, 16'hFFFF);     // checkpoint on an empty arena
      add_request(ACT_PUSH, 16'd0);         // zero bytes still takes a page
      add_request(ACT_PUSH, 16'd4096);      // exactly fills the rest of it
      add_request(ACT_PUSH, 16'd0);         // zero bytes at the full page
      add_request(ACT_BEGIN, 16'd0);
      add_request(ACT_PUSH, 16'hFFFF);      // larger than the default page
      add_request(ACT_PUSH, 16'd100);
      add_request(ACT_END, 16'd0);          // rollback frees the chained pages
      add_request(ACT_END, 16'd0);          // no checkpoint left: disposes
      add_request(ACT_PUSH, 16'd4095);      // reuses a backed page
      add_request(ACT_DISPOSE, 16'd0);
      for (int i = 0; i < 14; i++)          // run the pool dry, last one refused
         add_request(ACT_PUSH, 16'hFFFF);
      add_request(ACT_DISPOSE, 16'd0);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering requests.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      add_random_requests(60);
      start_hold <= 1'b1;
      wait_drained();
      add_request(ACT_DISPOSE, 16'd0);
      wait_drained();

      // Phases under different page defaults and idling patterns.
      write_page_default(16'd1);
      run_phase(160, 0, 0);
      write_page_default(16'hFFFF);
      run_phase(160, 56, 0);
      write_page_default(16'd0);            // unbacked pages may be backed empty
      run_phase(160, 0, 56);
      write_page_default(16'd300);
      run_phase(160, 6, 6);
      write_page_default(16'd4096);
      run_phase(160, 56, 56);
      write_page_default(16'($urandom_range(65535)));
      run_phase(140, 0, 0);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
